// File: rtl/eptof_pkg.sv
// Shared types and constants for the parabolic time-of-flight block.
// Holds the status codes, the fixed port widths, the item record and the period function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package eptof_pkg;

   localparam int IDX_PORT_W  = 16;
   localparam int ECHO_PORT_W = 48;
   localparam int PKT_W       = 8;
   localparam int TIME_W      = 36;
   localparam int DELTA_W     = 37;
   localparam int STATUS_W    = 2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FLAT  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // Everything about an item that does not take part in the division.
   typedef struct packed {
      logic [PKT_W-1:0]              packet_number;
      logic signed [ECHO_PORT_W-1:0] echo_early;
      logic signed [ECHO_PORT_W-1:0] echo_peak;
      logic signed [ECHO_PORT_W-1:0] echo_late;
      logic [TIME_W-1:0]             time_first;
      logic [TIME_W-1:0]             time_second;
      logic signed [DELTA_W-1:0]     base;
      logic                          neg;
      status_type                    status;
   } info_type;

   // Sample period of the 65 MHz clock in ns, rounded, with frac_bits fractional bits.
   function automatic logic [63:0] period_q(input int frac_bits);
      return ((64'd1000000000 << frac_bits) + 64'd32500000) / 64'd65000000;
   endfunction

endpackage

`default_nettype wire

// File: rtl/eptof_queue.sv
// Small first-in first-out queue between the front and the back of the block.
// Generic in width and depth; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module eptof_queue #(
   parameter int WIDTH      = 8,
   parameter int DEPTH_LOG2 = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int DEPTH = 1 << DEPTH_LOG2;

   logic [WIDTH-1:0]      store_ff [DEPTH];
   logic [DEPTH_LOG2-1:0] wr_ptr_ff, wr_ptr_in;
   logic [DEPTH_LOG2-1:0] rd_ptr_ff, rd_ptr_in;
   logic [DEPTH_LOG2:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = count_ff != (DEPTH_LOG2 + 1)'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = store_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/eptof_front.sv
// Front end: registers an accepted packet, widens the echoes, forms the curvature terms,
// classifies the item and computes both sample times and the whole-sample base delta.
// Depends on eptof_pkg.
`timescale 1ns / 1ps
`default_nettype none

module eptof_front
   import eptof_pkg::*;
#(
   parameter int FRAC_BITS  = 16,
   parameter int ECHO_BITS  = 48,
   parameter int INDEX_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [IDX_PORT_W-1:0]  req_index_first,
   input  wire logic [IDX_PORT_W-1:0]  req_index_second,
   input  wire logic [ECHO_PORT_W-1:0] req_echo_raw_early,
   input  wire logic [ECHO_PORT_W-1:0] req_echo_raw_peak,
   input  wire logic [ECHO_PORT_W-1:0] req_echo_raw_late,
   input  wire logic [PKT_W-1:0]       req_packet_number,
   output logic                        push_valid,
   input  wire logic                   push_ready,
   output info_type                    push_info,
   output logic [ECHO_BITS-1:0]        push_num,
   output logic [ECHO_BITS:0]          push_den
);

   localparam int PER_W  = FRAC_BITS + 4;
   localparam int DEN_W  = ECHO_BITS + 2;
   localparam int DMAG_W = ECHO_BITS + 1;
   localparam int NMAG_W = ECHO_BITS;
   localparam int TPROD_W = INDEX_BITS + PER_W;
   localparam int BASE_W = INDEX_BITS + PER_W + 2;
   localparam logic [PER_W-1:0] PERIOD = PER_W'(period_q(FRAC_BITS));

   logic                   vld_ff, vld_in;
   logic [INDEX_BITS-1:0]  ia_ff, ib_ff;
   logic [ECHO_BITS-1:0]   e1_ff, e2_ff, e3_ff;
   logic [PKT_W-1:0]       pkt_ff;
   logic                   take;

   logic signed [DEN_W-1:0]  y1, y2, y3, den, num, den_abs, num_abs;
   logic [DMAG_W-1:0]        den_mag;
   logic [NMAG_W-1:0]        num_mag;
   logic [TPROD_W-1:0]       t1, t2;
   logic signed [INDEX_BITS:0] idx_diff;
   logic signed [BASE_W-1:0] diff_ext, per_ext, base;

   assign req_ready = !vld_ff || push_ready;
   assign take      = req_valid && req_ready;
   assign vld_in    = req_ready ? req_valid : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ia_ff  <= req_index_first[INDEX_BITS-1:0];
         ib_ff  <= req_index_second[INDEX_BITS-1:0];
         e1_ff  <= req_echo_raw_early[ECHO_BITS-1:0];
         e2_ff  <= req_echo_raw_peak[ECHO_BITS-1:0];
         e3_ff  <= req_echo_raw_late[ECHO_BITS-1:0];
         pkt_ff <= req_packet_number;
      end
   end

   always_comb begin
      y1 = DEN_W'(signed'(e1_ff));
      y2 = DEN_W'(signed'(e2_ff));
      y3 = DEN_W'(signed'(e3_ff));
      den = y3 + y1 - (y2 <<< 1);
      num = y3 - y1;
      den_abs = den[DEN_W-1] ? -den : den;
      num_abs = num[DEN_W-1] ? -num : num;
      den_mag = den_abs[DMAG_W-1:0];
      num_mag = num_abs[NMAG_W-1:0];

      t1 = TPROD_W'(ia_ff) * TPROD_W'(PERIOD);
      t2 = TPROD_W'(ib_ff) * TPROD_W'(PERIOD);
      idx_diff = signed'({1'b0, ib_ff}) - signed'({1'b0, ia_ff});
      diff_ext = BASE_W'(idx_diff);
      per_ext  = BASE_W'(signed'({1'b0, PERIOD}));
      base     = diff_ext * per_ext;

      push_info.packet_number = pkt_ff;
      push_info.echo_early    = ECHO_PORT_W'(signed'(e1_ff));
      push_info.echo_peak     = ECHO_PORT_W'(signed'(e2_ff));
      push_info.echo_late     = ECHO_PORT_W'(signed'(e3_ff));
      push_info.time_first    = TIME_W'(t1);
      push_info.time_second   = TIME_W'(t2);
      push_info.base          = DELTA_W'(base);
      push_info.neg           = num[DEN_W-1] ^ den[DEN_W-1];
      if (den == '0) begin
         push_info.status = STATUS_FLAT;
      end else if ((DMAG_W + 1)'(num_mag) > {den_mag, 1'b0}) begin
         push_info.status = STATUS_RANGE;
      end else begin
         push_info.status = STATUS_OK;
      end
   end

   assign push_valid = vld_ff;
   assign push_num   = num_mag;
   assign push_den   = den_mag;

endmodule

`default_nettype wire

// File: rtl/eptof_back.sv
// Back end: a pipelined restoring divider for the sub-sample offset, the offset-to-time
// multiply, and the rounded final delta into the output register.
// Depends on eptof_pkg.
`timescale 1ns / 1ps
`default_nettype none

module eptof_back
   import eptof_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int ECHO_BITS = 48
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   output logic                      q_ready,
   input  wire info_type             q_info,
   input  wire logic [ECHO_BITS-1:0] q_num,
   input  wire logic [ECHO_BITS:0]   q_den,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output info_type                  rsp_info,
   output logic signed [DELTA_W-1:0] rsp_delta
);

   localparam int PER_W  = FRAC_BITS + 4;
   localparam int DMAG_W = ECHO_BITS + 1;
   localparam int DIV_N  = FRAC_BITS + 2;
   localparam int Q_W    = FRAC_BITS + 2;
   localparam int OFF_W  = FRAC_BITS + 1;
   localparam int PROD_W = OFF_W + PER_W;
   localparam int PART_W = PROD_W + 1 - FRAC_BITS;
   localparam logic [PER_W-1:0] PERIOD = PER_W'(period_q(FRAC_BITS));
   localparam logic [PROD_W:0]  HALF   = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

   // Whole pipeline advances together whenever the output register can take a result.
   logic en;

   logic [DIV_N-1:0]  vld_ff, vld_in;
   info_type          info_ff [DIV_N];
   info_type          info_in [DIV_N];
   logic [DMAG_W-1:0] rem_ff [DIV_N];
   logic [DMAG_W-1:0] rem_in [DIV_N];
   logic [DMAG_W-1:0] dvs_ff [DIV_N];
   logic [DMAG_W-1:0] dvs_in [DIV_N];
   logic [Q_W-1:0]    quo_ff [DIV_N];
   logic [Q_W-1:0]    quo_in [DIV_N];

   logic              mvld_ff, mvld_in;
   info_type          minfo_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [Q_W-1:0]    quo_up;
   logic [OFF_W-1:0]  off;

   logic              rvld_ff, rvld_in;
   info_type          rinfo_ff;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic [PROD_W:0]   rounded;
   logic [PART_W-1:0] part;

   assign en      = !rvld_ff || rsp_ready;
   assign q_ready = en;

   // Stage 0 takes off the multiple of two divisors, stage 1 the single divisor, and every
   // later stage doubles the remainder and yields one fractional quotient bit.
   for (genvar k = 0; k < DIV_N; k++) begin : g_stage
      logic              src_vld;
      info_type          src_info;
      logic [DMAG_W-1:0] src_rem, src_dvs;
      logic [Q_W-1:0]    src_quo;
      logic [DMAG_W:0]   trial, limit, rest;
      logic              hit;

      if (k == 0) begin : g_first
         assign src_vld  = q_valid;
         assign src_info = q_info;
         assign src_rem  = DMAG_W'(q_num);
         assign src_dvs  = q_den;
         assign src_quo  = '0;
      end else begin : g_next
         assign src_vld  = vld_ff[k-1];
         assign src_info = info_ff[k-1];
         assign src_rem  = rem_ff[k-1];
         assign src_dvs  = dvs_ff[k-1];
         assign src_quo  = quo_ff[k-1];
      end

      assign trial = (k >= 2) ? {src_rem, 1'b0} : {1'b0, src_rem};
      assign limit = (k == 0) ? {src_dvs, 1'b0} : {1'b0, src_dvs};
      assign hit   = trial >= limit;
      assign rest  = hit ? trial - limit : trial;

      assign vld_in[k]  = src_vld;
      assign info_in[k] = src_info;
      assign rem_in[k]  = rest[DMAG_W-1:0];
      assign dvs_in[k]  = src_dvs;
      assign quo_in[k]  = {src_quo[Q_W-2:0], hit};
   end

   // Quotient holds the offset with one extra fractional bit; adding one and dropping it
   // rounds half up.
   always_comb begin
      quo_up  = quo_ff[DIV_N-1] + 1'b1;
      off     = quo_up[Q_W-1:1];
      prod_in = PROD_W'(off) * PROD_W'(PERIOD);
      mvld_in = vld_ff[DIV_N-1];
   end

   always_comb begin
      rounded  = (PROD_W + 1)'(prod_ff) + HALF;
      part     = rounded[PROD_W:FRAC_BITS];
      rvld_in  = mvld_ff;
      if (minfo_ff.status != STATUS_OK) begin
         delta_in = '0;
      end else if (minfo_ff.neg) begin
         delta_in = minfo_ff.base - DELTA_W'(part);
      end else begin
         delta_in = minfo_ff.base + DELTA_W'(part);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         mvld_ff <= 1'b0;
         rvld_ff <= 1'b0;
      end else if (en) begin
         vld_ff  <= vld_in;
         mvld_ff <= mvld_in;
         rvld_ff <= rvld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < DIV_N; i++) begin
            info_ff[i] <= info_in[i];
            rem_ff[i]  <= rem_in[i];
            dvs_ff[i]  <= dvs_in[i];
            quo_ff[i]  <= quo_in[i];
         end
         minfo_ff <= info_ff[DIV_N-1];
         prod_ff  <= prod_in;
         rinfo_ff <= minfo_ff;
         delta_ff <= delta_in;
      end
   end

   assign rsp_valid = rvld_ff;
   assign rsp_info  = rinfo_ff;
   assign rsp_delta = delta_ff;

endmodule

`default_nettype wire

// File: rtl/echo_parabolic_time_of_flight.sv
// Top level of the parabolic time-of-flight block: front end, queue and back end.
// Depends on eptof_pkg, eptof_front, eptof_queue and eptof_back.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  two indices, three raw echoes, packet number
//   rsp_      out        rsp_valid / rsp_ready  packet number, echoes, times, delta, status
//
// One item is accepted per cycle and one result leaves per cycle while rsp_ready is high.
// A result passes through the front register, the queue, the FRAC_BITS + 2 divider stages,
// the product register and the output register; the divider yields one quotient bit per stage.
// Reset is synchronous and clears only the valid flags and the queue pointers and count.
// A stall on the result side freezes the back end; the queue and the front register keep
// taking items until the queue and the front register are full, and only then does req_ready drop.
`timescale 1ns / 1ps
`default_nettype none

module echo_parabolic_time_of_flight
   import eptof_pkg::*;
#(
   parameter int FRAC_BITS  = 16,
   parameter int ECHO_BITS  = 48,
   parameter int INDEX_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [IDX_PORT_W-1:0]  req_index_first,
   input  wire logic [IDX_PORT_W-1:0]  req_index_second,
   input  wire logic [ECHO_PORT_W-1:0] req_echo_raw_early,
   input  wire logic [ECHO_PORT_W-1:0] req_echo_raw_peak,
   input  wire logic [ECHO_PORT_W-1:0] req_echo_raw_late,
   input  wire logic [PKT_W-1:0]       req_packet_number,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [PKT_W-1:0]            rsp_packet_number_out,
   output logic signed [ECHO_PORT_W-1:0] rsp_echo_early,
   output logic signed [ECHO_PORT_W-1:0] rsp_echo_peak,
   output logic signed [ECHO_PORT_W-1:0] rsp_echo_late,
   output logic [TIME_W-1:0]           rsp_time_first_q16,
   output logic [TIME_W-1:0]           rsp_time_second_q16,
   output logic signed [DELTA_W-1:0]   rsp_flight_delta_q16,
   output logic [STATUS_W-1:0]         rsp_status
);

   localparam int QUEUE_LOG2 = 2;
   localparam int INFO_W     = $bits(info_type);
   localparam int ENTRY_W    = INFO_W + ECHO_BITS + ECHO_BITS + 1;

   // Front-end result: the item record plus the magnitudes of numerator and denominator.
   logic                 push_valid, push_ready;
   info_type             push_info;
   logic [ECHO_BITS-1:0] push_num;
   logic [ECHO_BITS:0]   push_den;

   logic                 pop_valid, pop_ready;
   logic [ENTRY_W-1:0]   pop_data;
   info_type             pop_info;
   logic [ECHO_BITS-1:0] pop_num;
   logic [ECHO_BITS:0]   pop_den;

   info_type             out_info;

   eptof_front #(
      .FRAC_BITS (FRAC_BITS),
      .ECHO_BITS (ECHO_BITS),
      .INDEX_BITS(INDEX_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_index_first   (req_index_first),
      .req_index_second  (req_index_second),
      .req_echo_raw_early(req_echo_raw_early),
      .req_echo_raw_peak (req_echo_raw_peak),
      .req_echo_raw_late (req_echo_raw_late),
      .req_packet_number (req_packet_number),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_info         (push_info),
      .push_num          (push_num),
      .push_den          (push_den)
   );

   // The queue lets the front end keep accepting items while the back end is stalled.
   eptof_queue #(
      .WIDTH     (ENTRY_W),
      .DEPTH_LOG2(QUEUE_LOG2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data ({push_info, push_num, push_den}),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data)
   );

   assign {pop_info, pop_num, pop_den} = pop_data;

   eptof_back #(
      .FRAC_BITS(FRAC_BITS),
      .ECHO_BITS(ECHO_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (pop_valid),
      .q_ready  (pop_ready),
      .q_info   (pop_info),
      .q_num    (pop_num),
      .q_den    (pop_den),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_info (out_info),
      .rsp_delta(rsp_flight_delta_q16)
   );

   // The flight delta is already forced to zero in the back end when the status flags a
   // flat curvature or an offset beyond one sample; the sample times always pass through.
   assign rsp_packet_number_out = out_info.packet_number;
   assign rsp_echo_early        = out_info.echo_early;
   assign rsp_echo_peak         = out_info.echo_peak;
   assign rsp_echo_late         = out_info.echo_late;
   assign rsp_time_first_q16    = out_info.time_first;
   assign rsp_time_second_q16   = out_info.time_second;
   assign rsp_status            = out_info.status;

endmodule

`default_nettype wire
